>>> rtl/slist_pkg.sv
package slist_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int VALUE_W = 32;
  localparam int TOTAL_W = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DELETED   = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic                      operation;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]                status;
    logic signed [VALUE_W-1:0] removed_value;
    logic [TOTAL_W-1:0]        entry_total;
  } out_item_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic                      cmp_en;
    logic                      ins_en;
    logic                      del_en;
    logic signed [VALUE_W-1:0] key;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } ctrl_state_t;

endpackage

>>> rtl/sorted_list_insert_delete.sv
// Sorted bounded multiset of signed 32-bit values, kept in ascending order
// in a row of cells. Each input transaction carries an operation and a value:
// an insert places the value in front of the first stored value that is not
// below it, and a delete removes one stored copy of the value. Every input
// transaction gives exactly one output transaction with a status, the removed
// value (zero unless the delete succeeded) and the number of stored values.
// An insert into a full store and a delete from an empty store or of an
// absent value leave the store unchanged and report that in the status.
// Each transaction passes through an accept step, a compare step in which
// every cell compares its entry against the value in parallel, and an apply
// step in which the cells shift toward or away from the insert or delete
// point and the result is registered. A new input is taken in the same cycle
// in which the result becomes valid; the block takes no new transaction
// until the previous one is through, as set by the compare and shift sequence
// of the cell row. Reset empties the store at once and clears the
// output valid. When the receiver holds stall high, the result stays in the
// output register. The block still accepts and compares one more
// transaction, then holds it in the apply step with in_stall high until the
// pending result has been taken.
module sorted_list_insert_delete #(
  parameter int CAPACITY = slist_pkg::DEFAULT_CAPACITY
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  slist_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output slist_pkg::out_item_t out_item
);
  import slist_pkg::*;

  cell_cmd_t                 cmd;
  logic signed [VALUE_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]       cell_valid;
  logic [CAPACITY-1:0]       cell_at;
  logic [CAPACITY-1:0]       cell_eq;

  // The controller sequences compare and apply, tracks the entry count and
  // owns the output register.
  slist_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .eq_flags (cell_eq),
    .cmd      (cmd)
  );

  // Cell zero has no left neighbor, and the last cell sees an empty slot on
  // its right, so a delete clears the last valid entry.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_value;
    logic                      left_valid;
    logic                      left_at;
    logic signed [VALUE_W-1:0] right_value;
    logic                      right_valid;

    if (i == 0) begin : g_first
      assign left_value = '0;
      assign left_valid = 1'b0;
      assign left_at    = 1'b0;
    end else begin : g_inner_left
      assign left_value = cell_value[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_at    = cell_at[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner_right
      assign right_value = cell_value[i+1];
      assign right_valid = cell_valid[i+1];
    end

    slist_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .prev_value(left_value),
      .prev_valid(left_valid),
      .prev_at   (left_at),
      .next_value(right_value),
      .next_valid(right_valid),
      .value     (cell_value[i]),
      .valid     (cell_valid[i]),
      .at_flag   (cell_at[i]),
      .eq_flag   (cell_eq[i])
    );
  end

endmodule

>>> rtl/slist_cell.sv
module slist_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  slist_pkg::cell_cmd_t               cmd,
  input  logic signed [slist_pkg::VALUE_W-1:0] prev_value,
  input  logic                               prev_valid,
  input  logic                               prev_at,
  input  logic signed [slist_pkg::VALUE_W-1:0] next_value,
  input  logic                               next_valid,
  output logic signed [slist_pkg::VALUE_W-1:0] value,
  output logic                               valid,
  output logic                               at_flag,
  output logic                               eq_flag
);
  import slist_pkg::*;

  logic ge_flag;

  // A cell is at or past the insert position when it is empty or holds a
  // value not below the key. Both conditions are monotonic along the chain.
  assign at_flag = !valid || ge_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      ge_flag <= 1'b0;
      eq_flag <= 1'b0;
    end else if (cmd.cmp_en) begin
      ge_flag <= valid && (value >= cmd.key);
      eq_flag <= valid && (value == cmd.key);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.ins_en) begin
      if (prev_at) begin
        valid <= prev_valid;
      end else if (at_flag) begin
        valid <= 1'b1;
      end
    end else if (cmd.del_en && ge_flag) begin
      valid <= next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_en) begin
      if (prev_at) begin
        value <= prev_value;
      end else if (at_flag) begin
        value <= cmd.key;
      end
    end else if (cmd.del_en && ge_flag) begin
      value <= next_value;
    end
  end

endmodule

>>> rtl/slist_ctrl.sv
module slist_ctrl #(
  parameter int CAPACITY = slist_pkg::DEFAULT_CAPACITY
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  slist_pkg::in_item_t   in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output slist_pkg::out_item_t  out_item,
  input  logic [CAPACITY-1:0]   eq_flags,
  output slist_pkg::cell_cmd_t  cmd
);
  import slist_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  ctrl_state_t state, state_next;
  logic                      op;
  logic signed [VALUE_W-1:0] key;
  logic [CNT_W-1:0]          count, count_next;
  logic                      found;
  logic                      commit;
  logic [2:0]                status_next;
  logic [CNT_W+TOTAL_W-1:0]  total_wide;

  assign found  = |eq_flags;
  assign commit = (state == S_APPLY) && !(out_valid && out_stall);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    cmd.cmp_en  = 1'b0;
    cmd.ins_en  = 1'b0;
    cmd.del_en  = 1'b0;
    cmd.key     = key;
    status_next = ST_INSERTED;
    count_next  = count;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_CMP: begin
        cmd.cmp_en = 1'b1;
      end
      S_APPLY: begin
        if (op == OP_INSERT) begin
          if (count == CAP_CNT) begin
            status_next = ST_FULL;
          end else begin
            status_next = ST_INSERTED;
            count_next  = count + CNT_W'(1);
            cmd.ins_en  = commit;
          end
        end else if (count == '0) begin
          status_next = ST_EMPTY;
        end else if (found) begin
          status_next = ST_DELETED;
          count_next  = count - CNT_W'(1);
          cmd.del_en  = commit;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign total_wide = {{TOTAL_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op  <= in_item.operation;
      key <= in_item.value;
    end
    if (commit) begin
      out_item.status        <= status_next;
      out_item.removed_value <= (status_next == ST_DELETED) ? key : '0;
      out_item.entry_total   <= total_wide[TOTAL_W-1:0];
    end
  end

endmodule
